// ===== rtl/core/jsap_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jsap_pkg: shared types and constants of the JSON string array parser
// Holds the item layouts of both channels, the parser state and the byte
// codes that the parser recognizes.
// ----------------------------------------------------------------------------
package jsap_pkg;

    // Parser phase, one-hot.
    typedef enum logic [4:0] {
        PH_START  = 5'b00001,
        PH_ARRAY  = 5'b00010,
        PH_STRING = 5'b00100,
        PH_ESCAPE = 5'b01000,
        PH_DONE   = 5'b10000
    } t_phase;

    typedef struct packed {
        t_phase phase;
        logic   string_nonempty;
    } t_state;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic       char_valid;
        logic [7:0] decoded_char;
        logic       string_end;
        logic       parse_done;
    } t_out_item;

    localparam logic [7:0] C_LBRACKET  = 8'h5B;
    localparam logic [7:0] C_RBRACKET  = 8'h5D;
    localparam logic [7:0] C_COMMA     = 8'h2C;
    localparam logic [7:0] C_QUOTE     = 8'h22;
    localparam logic [7:0] C_BACKSLASH = 8'h5C;
    localparam logic [7:0] C_LOWER_N   = 8'h6E;
    localparam logic [7:0] C_LOWER_R   = 8'h72;
    localparam logic [7:0] C_LOWER_T   = 8'h74;
    localparam logic [7:0] C_LF        = 8'h0A;
    localparam logic [7:0] C_CR        = 8'h0D;
    localparam logic [7:0] C_TAB       = 8'h09;
    localparam logic [7:0] C_SPACE     = 8'h20;

endpackage
`default_nettype wire

// ===== rtl/core/jsap_chan_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jsap_chan_if: valid/ready channel
// Carries one item of type T per handshake, with source and sink views.
// ----------------------------------------------------------------------------
interface jsap_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/json_string_array_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// json_string_array_parser: streaming parser for a JSON array of strings
// Takes text bytes with a final-byte flag and emits decoded string
// characters, string-end marks and a parse-done mark.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Item fields                                   | Items
//  --------+-----+-----------------------------------------------+-------------
//  i_in    | in  | text_byte[7:0], final_byte                    | one per byte
//  o_out   | out | char_valid, decoded_char[7:0], string_end,    | zero or one
//          |     | parse_done                                    | per byte
//
// Each byte passes through the input register and then, if it yields a
// result, waits in the output register until it is taken. One byte is taken
// every cycle while the output does not stall. The rate is set by the single
// parser state update, which runs once per byte between the two registers.
// Reset puts the parser in its start phase with both registers empty.
// A stall at the output holds the output register and the input register;
// the input still takes a byte while its own register is free.
//
module json_string_array_parser (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    jsap_chan_if.sink  i_in,
    jsap_chan_if.source o_out
);
    import jsap_pkg::*;

    // Input register: one byte waiting for the parser.
    logic      r_in_valid;
    t_in_item  r_in_item;

    // Parser state, updated once per byte that leaves the input register.
    t_state    r_state;
    t_state    n_state;

    // Output register: one result item waiting to be taken.
    logic      r_out_valid;
    t_out_item r_out_item;

    t_out_item step_result;
    logic      step_has_result;
    logic      advance;

    jsap_step u_step (
        .i_state      (r_state),
        .i_item       (r_in_item),
        .o_state      (n_state),
        .o_result     (step_result),
        .o_has_result (step_has_result)
    );

    // The byte in the input register moves on when the output register is
    // empty or is being emptied in this cycle. Bytes without a result simply
    // update the state and leave the output register as it is.
    assign advance    = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_item <= i_in.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase           <= PH_START;
            r_state.string_nonempty <= 1'b0;
            r_out_valid             <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && step_has_result;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid && step_has_result) begin
            r_out_item <= step_result;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_item;

endmodule
`default_nettype wire

// ===== rtl/core/jsap_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jsap_step: per-byte parser transition
// Computes the next parser state and the result item for one text byte.
// ----------------------------------------------------------------------------
module jsap_step (
    input  jsap_pkg::t_state    i_state,
    input  jsap_pkg::t_in_item  i_item,
    output jsap_pkg::t_state    o_state,
    output jsap_pkg::t_out_item o_result,
    output logic                o_has_result
);
    import jsap_pkg::*;

    function automatic logic [7:0] unescape(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c == C_LOWER_N) begin
            r = C_LF;
        end else if (c == C_LOWER_R) begin
            r = C_CR;
        end else if (c == C_LOWER_T) begin
            r = C_TAB;
        end
        return r;
    endfunction

    logic [7:0] c;
    logic       fin;
    logic       is_ws;
    logic       in_str;

    assign c     = i_item.text_byte;
    assign fin   = i_item.final_byte;
    assign is_ws = (c inside {[C_TAB:C_CR], C_SPACE});

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        in_str   = 1'b0;
        case (i_state.phase)
            PH_START: begin
                if (c == C_LBRACKET) begin
                    o_state.phase = PH_ARRAY;
                end else if (!is_ws) begin
                    o_state.phase       = PH_DONE;
                    o_result.parse_done = 1'b1;
                end
            end
            PH_ARRAY: begin
                if (c == C_QUOTE) begin
                    o_state.phase           = PH_STRING;
                    o_state.string_nonempty = 1'b0;
                end else if (!is_ws && c != C_COMMA) begin
                    o_state.phase       = PH_DONE;
                    o_result.parse_done = 1'b1;
                end
            end
            PH_STRING: begin
                in_str = 1'b1;
                if (c == C_QUOTE) begin
                    o_result.string_end     = i_state.string_nonempty;
                    o_state.string_nonempty = 1'b0;
                    o_state.phase           = PH_ARRAY;
                    in_str                  = 1'b0;
                end else if (c == C_BACKSLASH && !fin) begin
                    o_state.phase = PH_ESCAPE;
                end else begin
                    o_result.char_valid     = 1'b1;
                    o_result.decoded_char   = c;
                    o_state.string_nonempty = 1'b1;
                end
            end
            PH_ESCAPE: begin
                in_str                  = 1'b1;
                o_result.char_valid     = 1'b1;
                o_result.decoded_char   = unescape(c);
                o_state.string_nonempty = 1'b1;
                o_state.phase           = PH_STRING;
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase

        // The final byte closes any open string and any unfinished parse.
        if (fin) begin
            if (in_str && o_state.string_nonempty) begin
                o_result.string_end = 1'b1;
            end
            if (o_state.phase inside {PH_START, PH_ARRAY, PH_STRING, PH_ESCAPE}) begin
                o_result.parse_done = 1'b1;
            end
            o_state.phase           = PH_START;
            o_state.string_nonempty = 1'b0;
        end
    end

    assign o_has_result = o_result.char_valid | o_result.string_end | o_result.parse_done;

endmodule
`default_nettype wire
